// ===== hw/rtl/vmb_pkg.sv =====
// ----------------------------------------------------------------------------
// vmb_pkg
// Shared widths and fixed-point constants for the view matrix builder.
// ----------------------------------------------------------------------------
package vmb_pkg;

  localparam int VEC_W  = 16;   // Q2.14 basis components
  localparam int POS_W  = 32;   // Q16.16 positions and translations
  localparam int FRAC_W = 14;   // fraction bits of a basis component

  // Normalising unit stage counts
  localparam int NORM_SQ_STG = 16;  // two root bits per stage
  localparam int NORM_DV_STG = 8;   // two quotient bits per stage

  typedef logic [2:0][VEC_W-1:0] vec_t;
  typedef logic [2:0][POS_W-1:0] pos_t;

endpackage

// ===== hw/rtl/vmb_in_if.sv =====
// ----------------------------------------------------------------------------
// vmb_in_if
// Input channel: forward and right vectors plus camera position.
// ----------------------------------------------------------------------------
interface vmb_in_if import vmb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEC_W-1:0] fwd_x;
  logic signed [VEC_W-1:0] fwd_y;
  logic signed [VEC_W-1:0] fwd_z;
  logic signed [VEC_W-1:0] side_x;
  logic signed [VEC_W-1:0] side_y;
  logic signed [VEC_W-1:0] side_z;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, fwd_x, fwd_y, fwd_z, side_x, side_y, side_z,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, fwd_x, fwd_y, fwd_z, side_x, side_y, side_z,
                pos_x, pos_y, pos_z, output ready);
endinterface

// ===== hw/rtl/vmb_out_if.sv =====
// ----------------------------------------------------------------------------
// vmb_out_if
// Result channel: orthonormal view basis and translation row.
// ----------------------------------------------------------------------------
interface vmb_out_if import vmb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEC_W-1:0] out_side_x;
  logic signed [VEC_W-1:0] out_side_y;
  logic signed [VEC_W-1:0] out_side_z;
  logic signed [VEC_W-1:0] out_up_x;
  logic signed [VEC_W-1:0] out_up_y;
  logic signed [VEC_W-1:0] out_up_z;
  logic signed [VEC_W-1:0] out_fwd_x;
  logic signed [VEC_W-1:0] out_fwd_y;
  logic signed [VEC_W-1:0] out_fwd_z;
  logic signed [POS_W-1:0] trans_x;
  logic signed [POS_W-1:0] trans_y;
  logic signed [POS_W-1:0] trans_z;

  modport source (output valid, out_side_x, out_side_y, out_side_z, out_up_x,
                  out_up_y, out_up_z, out_fwd_x, out_fwd_y, out_fwd_z,
                  trans_x, trans_y, trans_z, input ready);
  modport sink (input valid, out_side_x, out_side_y, out_side_z, out_up_x,
                out_up_y, out_up_z, out_fwd_x, out_fwd_y, out_fwd_z,
                trans_x, trans_y, trans_z, output ready);
endinterface

// ===== hw/rtl/vmb_norm.sv =====
// ----------------------------------------------------------------------------
// vmb_norm
// Pipelined vector normaliser: range scaling, sum of squares, integer root
// and three restoring dividers. Carries a side payload alongside.
// ----------------------------------------------------------------------------
module vmb_norm import vmb_pkg::*; #(
  parameter int IN_W  = 16,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [2:0][IN_W-1:0] in_v,
  input  logic [PAY_W-1:0] in_pay,
  output logic             out_vld,
  output vec_t             out_n,
  output logic [PAY_W-1:0] out_pay
);

  localparam int NORM_W = 30;
  localparam int TOP    = NORM_W - 1;
  localparam int MSB_W  = $clog2(IN_W);
  localparam int SQ_W   = 2 * NORM_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int LEN_W  = 31;
  localparam int DEN_W  = LEN_W + 1;
  localparam int REM_W  = 48;
  localparam int QUO_W  = 16;
  localparam int SQ_STG = NORM_SQ_STG;
  localparam int DV_STG = NORM_DV_STG;
  localparam int SQ_TOP = 62;

  typedef struct packed {
    logic [2:0][NORM_W-1:0] a;
    logic [2:0]             neg;
    logic                   zero;
    logic [PAY_W-1:0]       pay;
  } side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_st_t;

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [63:0] b);
    sqrt_st_t    o;
    logic [63:0] t;
    t = s.root + b;
    if (s.rem >= t) begin
      o.rem  = s.rem - t;
      o.root = (s.root >> 1) + b;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  function automatic div_st_t div_step(div_st_t s, logic [REM_W-1:0] t);
    div_st_t o;
    o = s;
    if (s.rem >= t) begin
      o.rem = s.rem - t;
      o.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // ---- stage 1: magnitude, range scaling ----
  logic [2:0][IN_W-1:0]   mag;
  logic [IN_W-1:0]        mag_max;
  logic [MSB_W-1:0]       msb;
  logic [63:0]            scl;
  side_t                  s1_nxt;
  logic                   s1_vld_r;
  side_t                  s1_side_r;

  always_comb begin
    s1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.neg[i] = in_v[i][IN_W-1];
      mag[i] = in_v[i][IN_W-1] ? (IN_W'(0) - in_v[i]) : in_v[i];
    end
    mag_max = mag[0];
    if (mag[1] > mag_max) mag_max = mag[1];
    if (mag[2] > mag_max) mag_max = mag[2];
    msb = '0;
    for (int k = 0; k < IN_W; k++) begin
      if (mag_max[k]) msb = MSB_W'(k);
    end
    scl = '0;
    for (int i = 0; i < 3; i++) begin
      if (int'(msb) <= TOP) begin
        scl = 64'(mag[i]) << (TOP - int'(msb));
      end else begin
        scl = 64'(mag[i]) >> (int'(msb) - TOP);
      end
      s1_nxt.a[i] = scl[NORM_W-1:0];
    end
    s1_nxt.zero = (mag_max == '0);
    s1_nxt.pay  = in_pay;
  end

  // ---- stage 2: squares; stage 3: sum ----
  logic [2:0][SQ_W-1:0] s2_sq_r;
  logic                 s2_vld_r;
  side_t                s2_side_r;
  logic [SUM_W-1:0]     s3_sum_r;
  logic                 s3_vld_r;
  side_t                s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_nxt;
      for (int i = 0; i < 3; i++) begin
        s2_sq_r[i] <= SQ_W'(s1_side_r.a[i]) * SQ_W'(s1_side_r.a[i]);
      end
      s2_side_r <= s1_side_r;
      s3_sum_r  <= SUM_W'(s2_sq_r[0]) + SUM_W'(s2_sq_r[1]) + SUM_W'(s2_sq_r[2]);
      s3_side_r <= s2_side_r;
    end
  end

  // ---- integer square root, two result bits per stage ----
  sqrt_st_t sq_st_r   [SQ_STG];
  side_t    sq_side_r [SQ_STG];
  logic     sq_vld_r  [SQ_STG];

  for (genvar g = 0; g < SQ_STG; g++) begin : g_sqrt
    sqrt_st_t st_src, st_mid, st_nxt;
    side_t    sd_src;
    logic     vld_src;

    if (g == 0) begin : g_head
      assign st_src  = '{rem: 64'(s3_sum_r), root: 64'd0};
      assign sd_src  = s3_side_r;
      assign vld_src = s3_vld_r;
    end else begin : g_body
      assign st_src  = sq_st_r[g-1];
      assign sd_src  = sq_side_r[g-1];
      assign vld_src = sq_vld_r[g-1];
    end

    assign st_mid = sqrt_step(st_src, 64'd1 << (SQ_TOP - 4 * g));
    assign st_nxt = sqrt_step(st_mid, 64'd1 << (SQ_TOP - 2 - 4 * g));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[g] <= 1'b0;
      end else if (en) begin
        sq_vld_r[g] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_st_r[g]   <= st_nxt;
        sq_side_r[g] <= sd_src;
      end
    end
  end

  // ---- restoring division, q = (a*2^15 + len) / (2*len) ----
  div_st_t          dv_st_r   [DV_STG][3];
  logic [DEN_W-1:0] dv_d_r    [DV_STG];
  side_t            dv_side_r [DV_STG];
  logic             dv_vld_r  [DV_STG];

  for (genvar g = 0; g < DV_STG; g++) begin : g_div
    div_st_t          st_src [3];
    div_st_t          st_nxt [3];
    logic [DEN_W-1:0] d_src;
    side_t            sd_src;
    logic             vld_src;

    if (g == 0) begin : g_head
      logic [LEN_W-1:0] len;

      assign len = sq_st_r[SQ_STG-1].root[LEN_W-1:0];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign st_src[l] = '{
          rem: (REM_W'(sq_side_r[SQ_STG-1].a[l]) << 15) + REM_W'(len),
          quo: '0};
      end
      assign d_src   = {len, 1'b0};
      assign sd_src  = sq_side_r[SQ_STG-1];
      assign vld_src = sq_vld_r[SQ_STG-1];
    end else begin : g_body
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign st_src[l] = dv_st_r[g-1][l];
      end
      assign d_src   = dv_d_r[g-1];
      assign sd_src  = dv_side_r[g-1];
      assign vld_src = dv_vld_r[g-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        st_nxt[l] = div_step(div_step(st_src[l], REM_W'(d_src) << (QUO_W - 1 - 2 * g)),
                             REM_W'(d_src) << (QUO_W - 2 - 2 * g));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[g] <= 1'b0;
      end else if (en) begin
        dv_vld_r[g] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) dv_st_r[g][l] <= st_nxt[l];
        dv_d_r[g]    <= d_src;
        dv_side_r[g] <= sd_src;
      end
    end
  end

  // ---- sign and output register ----
  logic             o_vld_r;
  vec_t             o_n_r;
  vec_t             o_n_nxt;
  logic [PAY_W-1:0] o_pay_r;
  logic [QUO_W-1:0] qc;

  always_comb begin
    o_n_nxt = '0;
    qc      = '0;
    for (int l = 0; l < 3; l++) begin
      qc = dv_st_r[DV_STG-1][l].quo;
      if (qc[QUO_W-1]) qc = {1'b0, {(QUO_W-1){1'b1}}};
      if (dv_side_r[DV_STG-1].zero) begin
        o_n_nxt[l] = '0;
      end else if (dv_side_r[DV_STG-1].neg[l]) begin
        o_n_nxt[l] = VEC_W'(0) - VEC_W'(qc);
      end else begin
        o_n_nxt[l] = VEC_W'(qc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= dv_vld_r[DV_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_n_r   <= o_n_nxt;
      o_pay_r <= dv_side_r[DV_STG-1].pay;
    end
  end

  assign out_vld = o_vld_r;
  assign out_n   = o_n_r;
  assign out_pay = o_pay_r;

endmodule

// ===== hw/rtl/view_matrix_builder.sv =====
// One item per cycle, except while a result waits untaken.
// The two vector normalisers (28 stages each: scale, square, sum, 16 root
// stages, 8 divider stages, sign) set the depth.
// The whole pipeline holds while a result waits untaken; otherwise a new
// item is taken every cycle.
// Reset (rst_n, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// view_matrix_builder
// Builds an orthonormal camera basis and the view translation row.
// ----------------------------------------------------------------------------
module view_matrix_builder import vmb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  vmb_in_if.sink    in_ch,
  vmb_out_if.source out_ch
);

  localparam int PAY_W  = 3 * VEC_W + 3 * POS_W;
  localparam int PRD_W  = 2 * VEC_W;
  localparam int CRS_W  = PRD_W + 1;
  localparam int RND_W  = CRS_W + 1;
  localparam int DOT_W  = POS_W + VEC_W;
  localparam int ACC_W  = DOT_W + 3;

  function automatic logic [VEC_W-1:0] sat_vec(logic [RND_W-FRAC_W-1:0] v);
    localparam int W = RND_W - FRAC_W;
    if (v[W-1:VEC_W-1] != {(W-VEC_W+1){v[W-1]}}) begin
      return v[W-1] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
    end
    return v[VEC_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(logic [ACC_W-FRAC_W-1:0] v);
    localparam int W = ACC_W - FRAC_W;
    if (v[W-1:POS_W-1] != {(W-POS_W+1){v[W-1]}}) begin
      return v[W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return v[POS_W-1:0];
  endfunction

  logic en;
  logic o_vld_r;

  assign en          = !o_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---- input register ----
  logic i_vld_r;
  vec_t i_f_r, i_r_r;
  pos_t i_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_vld_r <= 1'b0;
    end else if (en) begin
      i_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_f_r <= {in_ch.fwd_z, in_ch.fwd_y, in_ch.fwd_x};
      i_r_r <= {in_ch.side_z, in_ch.side_y, in_ch.side_x};
      i_p_r <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    end
  end

  // ---- forward normalise ----
  logic             n1_vld;
  vec_t             n1_fn;
  logic [PAY_W-1:0] n1_pay;
  vec_t             n1_r;
  pos_t             n1_p;

  vmb_norm #(.IN_W(VEC_W), .PAY_W(PAY_W)) u_norm_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (i_vld_r),
    .in_v    (i_f_r),
    .in_pay  ({i_r_r, i_p_r}),
    .out_vld (n1_vld),
    .out_n   (n1_fn),
    .out_pay (n1_pay)
  );

  assign {n1_r, n1_p} = n1_pay;

  // ---- cross forward x right ----
  logic                  x1_vld_r, x2_vld_r;
  logic [5:0][PRD_W-1:0] x1_prod_r;
  vec_t                  x1_fn_r, x2_fn_r;
  pos_t                  x1_p_r, x2_p_r;
  logic [2:0][CRS_W-1:0] x2_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
    end else if (en) begin
      x1_vld_r <= n1_vld;
      x2_vld_r <= x1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x1_prod_r[2*i]   <= PRD_W'($signed(n1_fn[(i+1)%3]) * $signed(n1_r[(i+2)%3]));
        x1_prod_r[2*i+1] <= PRD_W'($signed(n1_fn[(i+2)%3]) * $signed(n1_r[(i+1)%3]));
        x2_c_r[i] <= {x1_prod_r[2*i][PRD_W-1], x1_prod_r[2*i]}
                   - {x1_prod_r[2*i+1][PRD_W-1], x1_prod_r[2*i+1]};
      end
      x1_fn_r <= n1_fn;
      x1_p_r  <= n1_p;
      x2_fn_r <= x1_fn_r;
      x2_p_r  <= x1_p_r;
    end
  end

  // ---- up normalise ----
  logic             n2_vld;
  vec_t             n2_up;
  logic [PAY_W-1:0] n2_pay;
  vec_t             n2_fn;
  pos_t             n2_p;

  vmb_norm #(.IN_W(CRS_W), .PAY_W(PAY_W)) u_norm_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (x2_vld_r),
    .in_v    (x2_c_r),
    .in_pay  ({x2_fn_r, x2_p_r}),
    .out_vld (n2_vld),
    .out_n   (n2_up),
    .out_pay (n2_pay)
  );

  assign {n2_fn, n2_p} = n2_pay;

  // ---- rebuilt right = up x forward, rounded to Q2.14 ----
  logic                  y1_vld_r, y2_vld_r;
  logic [5:0][PRD_W-1:0] y1_prod_r;
  vec_t                  y1_up_r, y1_fn_r, y2_up_r, y2_fn_r, y2_rn_r;
  pos_t                  y1_p_r, y2_p_r;
  logic [2:0][RND_W-1:0] rc_rnd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rc_rnd[i] = {{2{y1_prod_r[2*i][PRD_W-1]}}, y1_prod_r[2*i]}
                - {{2{y1_prod_r[2*i+1][PRD_W-1]}}, y1_prod_r[2*i+1]}
                + RND_W'(1 << (FRAC_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_vld_r <= 1'b0;
      y2_vld_r <= 1'b0;
    end else if (en) begin
      y1_vld_r <= n2_vld;
      y2_vld_r <= y1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        y1_prod_r[2*i]   <= PRD_W'($signed(n2_up[(i+1)%3]) * $signed(n2_fn[(i+2)%3]));
        y1_prod_r[2*i+1] <= PRD_W'($signed(n2_up[(i+2)%3]) * $signed(n2_fn[(i+1)%3]));
        y2_rn_r[i] <= sat_vec(rc_rnd[i][RND_W-1:FRAC_W]);
      end
      y1_up_r <= n2_up;
      y1_fn_r <= n2_fn;
      y1_p_r  <= n2_p;
      y2_up_r <= y1_up_r;
      y2_fn_r <= y1_fn_r;
      y2_p_r  <= y1_p_r;
    end
  end

  // ---- translation products ----
  logic                  d_vld_r;
  logic [8:0][DOT_W-1:0] d_prod_r;
  vec_t                  d_rn_r, d_up_r, d_fn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= y2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_prod_r[i]   <= DOT_W'($signed(y2_p_r[i]) * $signed(y2_rn_r[i]));
        d_prod_r[3+i] <= DOT_W'($signed(y2_p_r[i]) * $signed(y2_up_r[i]));
        d_prod_r[6+i] <= DOT_W'($signed(y2_p_r[i]) * $signed(y2_fn_r[i]));
      end
      d_rn_r <= y2_rn_r;
      d_up_r <= y2_up_r;
      d_fn_r <= y2_fn_r;
    end
  end

  // ---- negate, round, saturate; output register ----
  logic [2:0][ACC_W-1:0] acc;
  logic [2:0][POS_W-1:0] tr_nxt;
  vec_t                  o_rn_r, o_up_r, o_fn_r;
  logic [2:0][POS_W-1:0] o_tr_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = ACC_W'(1 << (FRAC_W - 1))
             - {{3{d_prod_r[3*j][DOT_W-1]}}, d_prod_r[3*j]}
             - {{3{d_prod_r[3*j+1][DOT_W-1]}}, d_prod_r[3*j+1]}
             - {{3{d_prod_r[3*j+2][DOT_W-1]}}, d_prod_r[3*j+2]};
      tr_nxt[j] = sat_pos(acc[j][ACC_W-1:FRAC_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_rn_r <= d_rn_r;
      o_up_r <= d_up_r;
      o_fn_r <= d_fn_r;
      o_tr_r <= tr_nxt;
    end
  end

  assign out_ch.valid      = o_vld_r;
  assign out_ch.out_side_x = o_rn_r[0];
  assign out_ch.out_side_y = o_rn_r[1];
  assign out_ch.out_side_z = o_rn_r[2];
  assign out_ch.out_up_x   = o_up_r[0];
  assign out_ch.out_up_y   = o_up_r[1];
  assign out_ch.out_up_z   = o_up_r[2];
  assign out_ch.out_fwd_x  = o_fn_r[0];
  assign out_ch.out_fwd_y  = o_fn_r[1];
  assign out_ch.out_fwd_z  = o_fn_r[2];
  assign out_ch.trans_x    = o_tr_r[0];
  assign out_ch.trans_y    = o_tr_r[1];
  assign out_ch.trans_z    = o_tr_r[2];

`ifndef SYNTH
  // A degenerate forward vector collapses the whole basis and translation.
  a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && o_fn_r == '0) |-> (o_up_r == '0 && o_rn_r == '0 && o_tr_r == '0))
    else $error("zero forward gave a non-zero basis");

  // Zero up (parallel inputs) leaves no right vector and no x/y translation.
  a_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && o_up_r == '0) |-> (o_rn_r == '0 && o_tr_r[0] == '0 && o_tr_r[1] == '0))
    else $error("zero up gave a non-zero right vector or translation");
`endif

endmodule
